/* sv/skvt_pkg.sv */
// shared types and constants for the sorted key/value table
// no dependencies
`default_nettype none

package skvt_pkg;

    localparam int KeyW = 128;
    localparam int ValW = 128;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_RANGE  = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_LOAD,
        S_SWEEP,
        S_APPLY,
        S_OUT
    } t_state;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic            load_cmp;
        logic [KeyW-1:0] cmp_key;
        logic            load_probe;
        logic            ins_mode;
        logic            shift;
        logic            apply_ins;
        logic            apply_del;
        logic [KeyW-1:0] new_key;
        logic [ValW-1:0] new_val;
    } t_cell_cmd;

    // keeps the first kb bytes of a key, byte 0 in the top bits
    function automatic logic [KeyW-1:0] key_mask(input int kb);
        logic [KeyW-1:0] m;
        m = '0;
        for (int b = 0; b < 16; b++) begin
            if (b < kb) m[KeyW-1-8*b -: 8] = 8'hFF;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* sv/skvt_cell.sv */
// one entry of the sorted table: stored key/value, compare flags and probe stage
// depends on skvt_pkg
`default_nettype none

module skvt_cell
    import skvt_pkg::*;
(
    input  wire              i_clk,
    input  wire t_cell_cmd   i_cmd,
    input  wire              i_valid,
    input  wire              i_prev_le,
    input  wire              i_next_le,
    input  wire [KeyW-1:0]   i_prev_key,
    input  wire [ValW-1:0]   i_prev_val,
    input  wire [KeyW-1:0]   i_next_key,
    input  wire [ValW-1:0]   i_next_val,
    input  wire              i_next_mk,
    input  wire [ValW-1:0]   i_next_pv,
    output logic             o_le,
    output logic [KeyW-1:0]  o_key,
    output logic [ValW-1:0]  o_val,
    output logic             o_mk,
    output logic [ValW-1:0]  o_pv
);

    logic [KeyW-1:0] r_key;
    logic [ValW-1:0] r_val;
    logic            r_le;
    logic            r_eq;
    logic            r_mk;
    logic [ValW-1:0] r_pv;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_cmp) begin
            r_le <= i_valid && (r_key <= i_cmd.cmp_key);
            r_eq <= i_valid && (r_key == i_cmd.cmp_key);
        end
        // insert marks the first cell past the equal keys, the rest mark the last equal
        if (i_cmd.load_probe) begin
            r_mk <= i_cmd.ins_mode ? (i_prev_le && !r_le) : (r_eq && !i_next_le);
            r_pv <= r_val;
        end else if (i_cmd.shift) begin
            r_mk <= i_next_mk;
            r_pv <= i_next_pv;
        end
        if (i_cmd.apply_ins) begin
            if (!i_prev_le) begin
                r_key <= i_prev_key;
                r_val <= i_prev_val;
            end else if (!r_le) begin
                r_key <= i_cmd.new_key;
                r_val <= i_cmd.new_val;
            end
        end else if (i_cmd.apply_del) begin
            if (!i_next_le) begin
                r_key <= i_next_key;
                r_val <= i_next_val;
            end
        end
    end

    assign o_le  = r_le;
    assign o_key = r_key;
    assign o_val = r_val;
    assign o_mk  = r_mk;
    assign o_pv  = r_pv;

endmodule

`default_nettype wire

/* sv/sorted_key_value_table.sv */
// sorted key/value table top level: controller and the row of entry cells
// depends on skvt_pkg and skvt_cell
`default_nettype none

// Holds up to CAPACITY entries in a row of cells kept in ascending key order.
// Every cell compares its key with the request at once; the matching
// position is then found by shifting a mark down the row to cell 0, one cell
// per cycle, where the number of shifts is the found position (or the entry
// count on a miss). Range count runs two such passes.
// Insert and delete then shift the entries in a single apply step.
// Full-table inserts skip the search and report ST_FULL. A new word is
// accepted while a finished result waits in the output register.
module sorted_key_value_table
    import skvt_pkg::*;
#(
    parameter int CAPACITY  = 1024,
    parameter int KEY_BYTES = 16
)
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [1:0]  i_operation,
    input  wire  [63:0] i_key_high,
    input  wire  [63:0] i_key_low,
    input  wire  [63:0] i_value_high,
    input  wire  [63:0] i_value_low,
    input  wire  [63:0] i_end_key_high,
    input  wire  [63:0] i_end_key_low,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [1:0]  o_status,
    output logic [9:0]  o_match_index,
    output logic [63:0] o_found_value_high,
    output logic [63:0] o_found_value_low,
    output logic [10:0] o_range_count,
    output logic [10:0] o_entries_held
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [KeyW-1:0] KEY_MASK = key_mask(KEY_BYTES);

    t_state r_state, n_state;

    logic [1:0]      r_op;
    logic [KeyW-1:0] r_key, r_ekey;
    logic [ValW-1:0] r_val;
    logic            r_phase2, n_phase2;
    logic [CW-1:0]   r_t, n_t;
    logic [CW-1:0]   r_p, n_p;
    logic [CW-1:0]   r_count, n_count;
    logic [1:0]      r_st, n_st;
    logic [CW-1:0]   r_ix, n_ix;
    logic [ValW-1:0] r_fv, n_fv;
    logic [CW-1:0]   r_rc, n_rc;
    logic            accept;
    logic [CW-1:0]   lo_pos, hi_pos;

    t_cell_cmd       cmd;
    logic [CAPACITY-1:0] cell_valid, cell_le, cell_mk;
    logic [KeyW-1:0] cell_key [CAPACITY];
    logic [ValW-1:0] cell_val [CAPACITY];
    logic [ValW-1:0] cell_pv  [CAPACITY];

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        cmd            = '0;
        cmd.cmp_key    = r_phase2 ? r_ekey : r_key;
        cmd.ins_mode   = (r_op == OP_INSERT);
        cmd.new_key    = r_key;
        cmd.new_val    = r_val;
        n_state  = r_state;
        n_phase2 = r_phase2;
        n_t      = r_t;
        n_p      = r_p;
        n_count  = r_count;
        n_st     = r_st;
        n_ix     = r_ix;
        n_fv     = r_fv;
        n_rc     = r_rc;
        lo_pos   = (r_t < r_p) ? r_t : r_p;
        hi_pos   = (r_t < r_p) ? r_p : r_t;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_phase2 = 1'b0;
                    n_st = ST_DONE;
                    n_ix = '0;
                    n_fv = '0;
                    n_rc = '0;
                    if (i_operation == OP_INSERT && r_count >= CW'(CAPACITY)) begin
                        n_st    = ST_FULL;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_CMP;
                    end
                end
            end
            S_CMP: begin
                cmd.load_cmp = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                cmd.load_probe = 1'b1;
                n_t = '0;
                n_state = S_SWEEP;
            end
            S_SWEEP: begin
                if (cell_mk[0]) begin
                    unique case (r_op)
                        OP_INSERT: begin
                            n_ix = r_t;
                            n_state = S_APPLY;
                        end
                        OP_LOOKUP: begin
                            n_ix = r_t;
                            n_fv = cell_pv[0];
                            n_state = S_OUT;
                        end
                        OP_DELETE: begin
                            n_ix = r_t;
                            n_fv = cell_pv[0];
                            n_state = S_APPLY;
                        end
                        default: begin
                            if (!r_phase2) begin
                                n_p = r_t;
                                n_phase2 = 1'b1;
                                n_state = S_CMP;
                            end else begin
                                n_ix = lo_pos;
                                n_rc = hi_pos - lo_pos + CW'(1);
                                n_state = S_OUT;
                            end
                        end
                    endcase
                end else if (r_t == r_count) begin
                    n_st = ST_MISSING;
                    n_ix = '0;
                    n_fv = '0;
                    n_rc = '0;
                    n_state = S_OUT;
                end else begin
                    cmd.shift = 1'b1;
                    n_t = r_t + CW'(1);
                end
            end
            S_APPLY: begin
                if (r_op == OP_INSERT) begin
                    cmd.apply_ins = 1'b1;
                    n_count = r_count + CW'(1);
                end else begin
                    cmd.apply_del = 1'b1;
                    n_count = r_count - CW'(1);
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!o_valid || i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_phase2 <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_phase2 <= n_phase2;
            if (r_state == S_OUT && (!o_valid || i_ready)) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_operation;
            r_key  <= {i_key_high, i_key_low} & KEY_MASK;
            r_ekey <= {i_end_key_high, i_end_key_low} & KEY_MASK;
            r_val  <= {i_value_high, i_value_low};
        end
        r_t  <= n_t;
        r_p  <= n_p;
        r_st <= n_st;
        r_ix <= n_ix;
        r_fv <= n_fv;
        r_rc <= n_rc;
        if (r_state == S_OUT && (!o_valid || i_ready)) begin
            o_status           <= r_st;
            o_match_index      <= 10'(r_ix);
            o_found_value_high <= r_fv[127:64];
            o_found_value_low  <= r_fv[63:0];
            o_range_count      <= 11'(r_rc);
            o_entries_held     <= 11'(r_count);
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic            prev_le, next_le, next_mk;
        logic [KeyW-1:0] prev_key, next_key;
        logic [ValW-1:0] prev_val, next_val, next_pv;

        assign cell_valid[g] = (CW'(g) < r_count);

        if (g == 0) begin : g_first
            assign prev_le  = 1'b1;
            assign prev_key = r_key;
            assign prev_val = r_val;
        end else begin : g_mid
            assign prev_le  = cell_le[g-1];
            assign prev_key = cell_key[g-1];
            assign prev_val = cell_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign next_le  = 1'b0;
            assign next_key = cell_key[g];
            assign next_val = cell_val[g];
            assign next_mk  = 1'b0;
            assign next_pv  = '0;
        end else begin : g_inner
            assign next_le  = cell_le[g+1];
            assign next_key = cell_key[g+1];
            assign next_val = cell_val[g+1];
            assign next_mk  = cell_mk[g+1];
            assign next_pv  = cell_pv[g+1];
        end

        skvt_cell u_cell (
            .i_clk      (i_clk),
            .i_cmd      (cmd),
            .i_valid    (cell_valid[g]),
            .i_prev_le  (prev_le),
            .i_next_le  (next_le),
            .i_prev_key (prev_key),
            .i_prev_val (prev_val),
            .i_next_key (next_key),
            .i_next_val (next_val),
            .i_next_mk  (next_mk),
            .i_next_pv  (next_pv),
            .o_le       (cell_le[g]),
            .o_key      (cell_key[g]),
            .o_val      (cell_val[g]),
            .o_mk       (cell_mk[g]),
            .o_pv       (cell_pv[g])
        );
    end

endmodule

`default_nettype wire
